/* rtl/core/mwc_rrg_pkg.sv */
// Package for the multiply-with-carry random range generator.
// Shared constants and the divider control/status structs; no dependencies.
package mwc_rrg_pkg;

   localparam int DATA_W = 32;
   localparam int HALF_W = DATA_W / 2;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   localparam logic [DATA_W-1:0] RANDOM_MAX = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] SEED_B = 32'd521288629;
   localparam logic [DATA_W-1:0] SEED_RESET = 32'd362436069;

   localparam logic [DATA_W-1:0] MULT_HIGH = 32'd36969;
   localparam logic [DATA_W-1:0] MULT_LOW = 32'd18000;
   localparam logic [DATA_W-1:0] HALF_MASK = 32'd65535;

   localparam logic [DATA_W-1:0] ONE = 32'd1;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

   typedef struct packed {
      logic start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/core/mwc_random_range_generator_core.sv */
// Top level of the multiply-with-carry random range generator: sequencer,
// operand registers and result register. Depends on mwc_rrg_pkg, mwc_rrg_gen, mwc_rrg_div.
//
//   port group | direction | handshake        | payload
//   req_       | in        | req_valid/ready  | mode, range_min, range_max
//   rsp_       | out       | rsp_valid/ready  | random_value, rejected
//   csr_       | in        | csr_we           | csr_wdata (seed)
//
// rsp_valid rises after the DRAW state for raw draws; rejected ranges go straight to RESULT.
// Scaled draws pass through DRAW, then make two passes through the shared
// divider (bucket size, then raw / bucket), each ended by the divider's done pulse.
// A span of zero skips the first pass. req_ready is high only when idle, so
// the next item is accepted at the earliest in the cycle after a result is taken; a result
// holds in rsp_ until taken. Synchronous reset restores the seed's reset value and both halves.
module mwc_random_range_generator_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_mode,
   input  logic [31:0] req_range_min,
   input  logic [31:0] req_range_max,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [31:0] rsp_random_value,
   output logic rsp_rejected,
   input  logic csr_we,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [4:0] {
      IDLE   = 5'b00001,
      DRAW   = 5'b00010,
      SPAN   = 5'b00100,
      QUOT   = 5'b01000,
      RESULT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic mode_ff, mode_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] min_ff, min_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] span_ff, span_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] value_ff, value_in;
   logic rej_ff, rej_in;

   logic accept;
   logic bad_range;
   logic advance;
   logic [mwc_rrg_pkg::DATA_W-1:0] raw;
   logic [mwc_rrg_pkg::DATA_W-1:0] quotient;
   logic [mwc_rrg_pkg::DATA_W-1:0] bucket;
   mwc_rrg_pkg::div_ctrl_type div_ctrl;
   mwc_rrg_pkg::div_stat_type div_stat;

   mwc_rrg_gen u_gen (
      .clock(clock),
      .reset(reset),
      .load(csr_we),
      .load_value(csr_wdata),
      .advance(advance),
      .raw(raw)
   );

   mwc_rrg_div u_div (
      .clock(clock),
      .reset(reset),
      .ctrl(div_ctrl),
      .stat(div_stat),
      .quotient(quotient)
   );

   assign req_ready = (state_ff == IDLE);
   assign accept = req_valid && req_ready;
   assign bad_range = (req_range_min >= req_range_max)
                      || (req_range_max > mwc_rrg_pkg::RANDOM_MAX);
   assign advance = accept && !(req_mode && bad_range);
   assign bucket = (quotient == '0) ? mwc_rrg_pkg::ONE : quotient;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      min_in = min_ff;
      span_in = span_ff;
      value_in = value_ff;
      rej_in = rej_ff;
      div_ctrl.start = 1'b0;
      div_ctrl.dividend = raw;
      div_ctrl.divisor = bucket;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               min_in = req_range_min;
               span_in = req_range_max + mwc_rrg_pkg::ONE - req_range_min;
               if (req_mode && bad_range) begin
                  value_in = '0;
                  rej_in = 1'b1;
                  state_in = RESULT;
               end else begin
                  state_in = DRAW;
               end
            end
         end
         DRAW: begin
            // halves have advanced; raw is the new draw
            if (!mode_ff) begin
               value_in = raw;
               rej_in = 1'b0;
               state_in = RESULT;
            end else if (span_ff == '0) begin
               div_ctrl.start = 1'b1;
               div_ctrl.divisor = mwc_rrg_pkg::ONE;
               state_in = QUOT;
            end else begin
               div_ctrl.start = 1'b1;
               div_ctrl.dividend = mwc_rrg_pkg::RANDOM_MAX;
               div_ctrl.divisor = span_ff;
               state_in = SPAN;
            end
         end
         SPAN: begin
            if (div_stat.done) begin
               div_ctrl.start = 1'b1;
               state_in = QUOT;
            end
         end
         QUOT: begin
            if (div_stat.done) begin
               value_in = quotient + min_ff;
               rej_in = 1'b0;
               state_in = RESULT;
            end
         end
         RESULT: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
      min_ff <= min_in;
      span_ff <= span_in;
      value_ff <= value_in;
      rej_ff <= rej_in;
   end

   assign rsp_valid = (state_ff == RESULT);
   assign rsp_random_value = value_ff;
   assign rsp_rejected = rej_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_random_value == '0)
      else $error("rejected item carries a nonzero value");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == SPAN || state_ff == QUOT))
      else $error("divider finished outside a division state");

   a_reject_holds_state: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode && bad_range && !csr_we |=> raw == $past(raw))
      else $error("generator advanced on a rejected item");

endmodule

/* rtl/core/mwc_rrg_gen.sv */
// Generator state: the two lag-1 multiply-with-carry halves and the raw draw.
// Depends on mwc_rrg_pkg.
module mwc_rrg_gen (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic [mwc_rrg_pkg::DATA_W-1:0] load_value,
   input  logic advance,
   output logic [mwc_rrg_pkg::DATA_W-1:0] raw
);

   logic [mwc_rrg_pkg::DATA_W-1:0] low_ff, low_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] high_ff, high_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] low_next, high_next;

   always_comb begin
      high_next = mwc_rrg_pkg::MULT_HIGH * (high_ff & mwc_rrg_pkg::HALF_MASK)
                  + (high_ff >> mwc_rrg_pkg::HALF_W);
      low_next = mwc_rrg_pkg::MULT_LOW * (low_ff & mwc_rrg_pkg::HALF_MASK)
                 + (low_ff >> mwc_rrg_pkg::HALF_W);
      low_in = low_ff;
      high_in = high_ff;
      priority if (load) begin
         low_in = load_value;
         high_in = mwc_rrg_pkg::SEED_B;
      end else if (advance) begin
         low_in = low_next;
         high_in = high_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= mwc_rrg_pkg::SEED_RESET;
         high_ff <= mwc_rrg_pkg::SEED_B;
      end else begin
         low_ff <= low_in;
         high_ff <= high_in;
      end
   end

   // raw draw of the current halves, valid the cycle after an advance
   assign raw = (high_ff << mwc_rrg_pkg::HALF_W) + low_ff;

endmodule

/* rtl/core/mwc_rrg_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on mwc_rrg_pkg.
module mwc_rrg_div (
   input  logic clock,
   input  logic reset,
   input  mwc_rrg_pkg::div_ctrl_type ctrl,
   output mwc_rrg_pkg::div_stat_type stat,
   output logic [mwc_rrg_pkg::DATA_W-1:0] quotient
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [mwc_rrg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [mwc_rrg_pkg::DATA_W:0] rem_ff, rem_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] quo_ff, quo_in;
   logic [mwc_rrg_pkg::DATA_W-1:0] dsr_ff, dsr_in;
   logic [mwc_rrg_pkg::DATA_W:0] rem_shift;
   logic fits;

   always_comb begin
      rem_shift = {rem_ff[mwc_rrg_pkg::DATA_W-1:0], quo_ff[mwc_rrg_pkg::DATA_W-1]};
      fits = rem_shift >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      priority if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = ctrl.dividend;
         dsr_in = ctrl.divisor;
      end else if (busy_ff) begin
         // dividend bits shift out of quo_ff as quotient bits shift in
         rem_in = fits ? rem_shift - {1'b0, dsr_ff} : rem_shift;
         quo_in = {quo_ff[mwc_rrg_pkg::DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mwc_rrg_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient = quo_ff;

endmodule
